FILE: design/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

  localparam int unsigned CODE_W        = 16;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned MAX_CODE_BITS = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PEND_W        = BYTE_W - 1;
  localparam int unsigned ACC_W         = PEND_W + MAX_CODE_BITS;
  localparam int unsigned CNT_W         = $clog2(ACC_W + 1);

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic load;
    logic emit;
  } mbp_cmd_t;

  typedef struct packed {
    logic byte_ready;
    logic merge_byte;
    logic out_free;
    logic last_next;
  } mbp_status_t;

endpackage

`default_nettype wire

FILE: design/mbp_datapath.sv
// Datapath of the bit packer: bit accumulator, merge logic and output register.
`timescale 1ns / 1ps
`default_nettype none

module mbp_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mbp_pkg::mbp_cmd_t           cmd_i,
  output mbp_pkg::mbp_status_t             sts_o,
  input  wire logic                        command_i,
  input  wire logic [mbp_pkg::CODE_W-1:0]  code_value_i,
  input  wire logic [mbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mbp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             last_byte_o
);
  import mbp_pkg::*;

  function automatic logic [ACC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ACC_W:0] one_sh;
    one_sh = (ACC_W + 1)'(1) << n;
    return one_sh[ACC_W-1:0] - ACC_W'(1);
  endfunction

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [ACC_W-1:0]  merge_acc;
  logic [CNT_W-1:0]  merge_total;
  logic [LEN_W-1:0]  len_sat;
  logic [ACC_W-1:0]  pend;
  logic [ACC_W-1:0]  code_bits;
  logic [ACC_W-1:0]  shifted;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              last_q, last_d;
  logic              out_free;

  always_comb begin
    len_sat = (code_length_i > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                       : code_length_i;
    pend      = acc_q & low_mask(total_q);
    code_bits = ACC_W'(code_value_i) & low_mask(CNT_W'(len_sat));
    merge_acc   = acc_q;
    merge_total = total_q;
    if (command_i == CMD_FLUSH) begin
      if (total_q != '0) begin
        merge_acc   = pend << (CNT_W'(BYTE_W) - total_q);
        merge_total = CNT_W'(BYTE_W);
      end
    end else if (len_sat != '0) begin
      merge_acc   = (pend << len_sat) | code_bits;
      merge_total = total_q + CNT_W'(len_sat);
    end
  end

  always_comb begin
    shifted  = acc_q >> (total_q - CNT_W'(BYTE_W));
    out_free = !out_valid_q || !out_stall_i;

    acc_d   = acc_q;
    total_d = total_q;
    if (cmd_i.load) begin
      acc_d   = merge_acc;
      total_d = merge_total;
    end else if (cmd_i.emit) begin
      total_d = total_q - CNT_W'(BYTE_W);
    end

    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = shifted[BYTE_W-1:0];
      last_d      = (total_q < CNT_W'(2 * BYTE_W));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign sts_o.byte_ready = (total_q >= CNT_W'(BYTE_W));
  assign sts_o.merge_byte = (merge_total >= CNT_W'(BYTE_W));
  assign sts_o.out_free   = out_free;
  assign sts_o.last_next  = (total_q < CNT_W'(2 * BYTE_W));

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

FILE: design/mbp_ctrl.sv
// Controller state machine of the bit packer.
`timescale 1ns / 1ps
`default_nettype none

module mbp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire mbp_pkg::mbp_status_t sts_i,
  output mbp_pkg::mbp_cmd_t         cmd_o
);
  import mbp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } mbp_state_e;

  mbp_state_e state_q, state_d;

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.emit = (state_q == S_EMIT) && sts_i.byte_ready && sts_i.out_free;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.merge_byte) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts_i.byte_ready || (cmd_o.emit && sts_i.last_next)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: design/msb_first_bit_packer_top.sv
// Top level of the MSB-first variable-width bit packer.
// A request is merged into the bit accumulator while idle; its bytes then move in the emit state to the output.
// The input is stalled while the completed bytes of a request (0 to 2) pass one at a time through the
// single byte-wide output register; output stalls hold the input stalled for longer.
// Reset: asynchronous, active low; clears the pending bit count and the output valid, and idles the controller.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_packer_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [mbp_pkg::CODE_W-1:0]  code_value_i,
  input  wire logic [mbp_pkg::LEN_W-1:0]   code_length_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [mbp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             last_byte_o
);
  import mbp_pkg::*;

  mbp_cmd_t    cmd;
  mbp_status_t sts;

  mbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mbp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .code_value_i  (code_value_i),
    .code_length_i (code_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o)
  );

  a_emit_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.byte_ready)
    else $error("emit without a complete byte");

  a_idle_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.byte_ready)
    else $error("complete byte left behind while idle");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.last_next) |=> (!in_stall_o && out_valid_o && last_byte_o))
    else $error("last byte did not end the request");

  a_no_load_and_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

endmodule

`default_nettype wire
